### sv/hds_pkg.sv
// shared types and constants of the heat diffusion stencil
package hds_pkg;

   localparam int ACTION_W    = 2;
   localparam int ROW_W       = 6;
   localparam int COL_W       = 6;
   localparam int VALUE_W     = 24;
   localparam int SUM_W       = 26;
   localparam int SIDE_REG_W  = 7;
   localparam int TICK_W      = 10;
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 10;

   // item actions
   localparam logic [ACTION_W-1:0] ACT_WRITE = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_RUN   = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_READ  = 2'd2;

   // reply kinds
   localparam logic REPLY_READ = 1'b0;
   localparam logic REPLY_DONE = 1'b1;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_SIDE  = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_TICKS = 1'd1;

   localparam logic [SIDE_REG_W-1:0] SIDE_RESET  = 7'd10;
   localparam logic [TICK_W-1:0]     TICKS_RESET = 10'd10;

   typedef struct packed {
      logic [ACTION_W-1:0]      action;
      logic [ROW_W-1:0]         row;
      logic [COL_W-1:0]         col;
      logic signed [VALUE_W-1:0] value;
   } req_type;

   typedef struct packed {
      logic                      reply_kind;
      logic signed [VALUE_W-1:0] cell_value;
   } rsp_type;

endpackage

### sv/heat_diffusion_stencil.sv
// jacobi heat diffusion grid with ping-pong stores and a shared accumulator
// write transaction: stored on acceptance; read transaction: registered store read, then reply
// run transaction: each sweep steps every cell through cell, read and write states;
// copied cells read one operand, averaged four, over a single read port and one adder;
// the done reply follows the last sweep; no new transaction is taken during a read or run
// synchronous active-high reset clears state, store select, reply valid and config only
module heat_diffusion_stencil #(
   parameter int MAX_SIDE = 64
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  hds_pkg::req_type                     req_data,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output hds_pkg::rsp_type                     rsp_data,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [hds_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [hds_pkg::CSR_DATA_W-1:0]       csr_wdata
);
   import hds_pkg::*;

   // geometry derived from the largest grid
   localparam int IDX_W  = $clog2(MAX_SIDE);
   localparam int SIDE_W = $clog2(MAX_SIDE + 1);
   localparam int ADDR_W = 2 * IDX_W;
   localparam int DEPTH  = 1 << ADDR_W;
   // one spare bit so that MAX_SIDE itself fits the bound compare
   localparam int EXT_W  = ((IDX_W > ROW_W) ? IDX_W : ROW_W) + 1;
   localparam int CMP_W  = (SIDE_W > SIDE_REG_W) ? SIDE_W : SIDE_REG_W;

   typedef enum logic [5:0] {
      S_IDLE  = 6'b000001,
      S_RDATA = 6'b000010,
      S_CELL  = 6'b000100,
      S_READ  = 6'b001000,
      S_WRITE = 6'b010000,
      S_DONE  = 6'b100000
   } state_type;

   // control state
   state_type              state_ff, state_in;
   logic                   cur_b_ff, cur_b_in;
   logic [TICK_W-1:0]      ticks_ff, ticks_in;
   logic [IDX_W-1:0]       i_ff, i_in;
   logic [IDX_W-1:0]       j_ff, j_in;
   logic [1:0]             nb_ff, nb_in;
   logic                   stencil_ff, stencil_in;
   logic                   rd_zero_ff, rd_zero_in;
   logic signed [SUM_W-1:0] acc_ff, acc_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_type                rsp_ff, rsp_in;

   // configuration
   logic [SIDE_REG_W-1:0]  side_ff;
   logic [TICK_W-1:0]      tick_count_ff;

   // grid stores, one write and one registered read port each
   logic [VALUE_W-1:0]     grid_a_ff [DEPTH];
   logic [VALUE_W-1:0]     grid_b_ff [DEPTH];
   logic [VALUE_W-1:0]     rd_a_ff, rd_b_ff;
   logic                   rd_en, we_a, we_b;
   logic [ADDR_W-1:0]      rd_addr, wr_addr;
   logic [VALUE_W-1:0]     wr_data, rd_data;

   // item decode
   logic [EXT_W-1:0]       row_ext, col_ext;
   logic                   in_store;
   logic [ADDR_W-1:0]      item_addr;
   logic                   req_fire;

   // sweep geometry
   logic [CMP_W-1:0]       side_ext, side_cmp;
   logic [SIDE_W-1:0]      s_eff, mid, i_ext, j_ext, i_nxt, j_nxt;
   logic                   interior, fixed_cell, stencil_now;
   logic                   last_col, last_row;
   logic [ADDR_W-1:0]      cell_addr;
   logic [1:0]             op_sel;
   logic                   op_stencil;
   logic [ADDR_W-1:0]      op_addr;

   // shared adder
   logic signed [SUM_W-1:0] data_ext, acc_shr;
   logic                   first_op;
   logic                   out_free;

   assign csr_ready = 1'b1;
   assign req_ready = (state_ff == S_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   // cells beyond the store are ignored on write and read back as zero
   assign row_ext   = EXT_W'(req_data.row);
   assign col_ext   = EXT_W'(req_data.col);
   assign in_store  = (row_ext < EXT_W'(MAX_SIDE)) && (col_ext < EXT_W'(MAX_SIDE));
   assign item_addr = {row_ext[IDX_W-1:0], col_ext[IDX_W-1:0]};

   // effective side, clamped to the store
   assign side_ext = CMP_W'(side_ff);
   assign side_cmp = (side_ext > CMP_W'(MAX_SIDE)) ? CMP_W'(MAX_SIDE) : side_ext;
   assign s_eff    = side_cmp[SIDE_W-1:0];
   assign mid      = s_eff >> 1;

   assign i_ext = SIDE_W'(i_ff);
   assign j_ext = SIDE_W'(j_ff);
   assign i_nxt = i_ext + SIDE_W'(1);
   assign j_nxt = j_ext + SIDE_W'(1);

   assign interior   = (i_ff != '0) && (i_nxt < s_eff) && (j_ff != '0) && (j_nxt < s_eff);
   // the centre cell and cell one-one are held fixed
   assign fixed_cell = ((i_ext == mid) && (j_ext == mid))
                       || ((i_ff == IDX_W'(1)) && (j_ff == IDX_W'(1)));
   assign stencil_now = interior && !fixed_cell;
   assign last_col   = (j_nxt == s_eff);
   assign last_row   = (i_nxt == s_eff);
   assign cell_addr  = {i_ff, j_ff};

   // operand address: up, down, left, right, or the cell itself when copied
   assign op_sel     = (state_ff == S_CELL) ? 2'd0 : nb_ff + 2'd1;
   assign op_stencil = (state_ff == S_CELL) ? stencil_now : stencil_ff;

   always_comb begin
      op_addr = cell_addr;
      if (op_stencil) begin
         case (op_sel)
            2'd0:    op_addr = {i_ff - IDX_W'(1), j_ff};
            2'd1:    op_addr = {i_ff + IDX_W'(1), j_ff};
            2'd2:    op_addr = {i_ff, j_ff - IDX_W'(1)};
            2'd3:    op_addr = {i_ff, j_ff + IDX_W'(1)};
            default: op_addr = cell_addr;
         endcase
      end
   end

   // reads always come from the current store
   assign rd_data  = cur_b_ff ? rd_b_ff : rd_a_ff;
   assign data_ext = {{(SUM_W - VALUE_W){rd_data[VALUE_W-1]}}, rd_data};
   assign first_op = !stencil_ff || (nb_ff == 2'd0);
   // arithmetic shift floors the four-neighbour sum
   assign acc_shr  = acc_ff >>> 2;

   always_comb begin
      state_in     = state_ff;
      cur_b_in     = cur_b_ff;
      ticks_in     = ticks_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      nb_in        = nb_ff;
      stencil_in   = stencil_ff;
      rd_zero_in   = rd_zero_ff;
      acc_in       = acc_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      rd_en        = 1'b0;
      rd_addr      = item_addr;
      we_a         = 1'b0;
      we_b         = 1'b0;
      wr_addr      = item_addr;
      wr_data      = req_data.value;

      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               case (req_data.action)
                  ACT_WRITE: begin
                     we_a = in_store && !cur_b_ff;
                     we_b = in_store && cur_b_ff;
                  end
                  ACT_RUN: begin
                     ticks_in = tick_count_ff;
                     i_in     = '0;
                     j_in     = '0;
                     state_in = (tick_count_ff == '0) ? S_DONE : S_CELL;
                  end
                  ACT_READ: begin
                     rd_en      = 1'b1;
                     rd_zero_in = !in_store;
                     state_in   = S_RDATA;
                  end
                  default: begin
                     state_in = S_IDLE;
                  end
               endcase
            end
         end
         S_RDATA: begin
            if (out_free) begin
               rsp_valid_in      = 1'b1;
               rsp_in.reply_kind = REPLY_READ;
               rsp_in.cell_value = rd_zero_ff ? '0 : rd_data;
               state_in          = S_IDLE;
            end
         end
         S_CELL: begin
            if (s_eff == '0) begin
               // empty grid: the sweep only swaps the stores
               cur_b_in = !cur_b_ff;
               ticks_in = ticks_ff - TICK_W'(1);
               state_in = (ticks_ff == TICK_W'(1)) ? S_DONE : S_CELL;
            end else begin
               rd_en      = 1'b1;
               rd_addr    = op_addr;
               stencil_in = stencil_now;
               nb_in      = 2'd0;
               state_in   = S_READ;
            end
         end
         S_READ: begin
            acc_in = (first_op ? '0 : acc_ff) + data_ext;
            if (stencil_ff && (nb_ff != 2'd3)) begin
               rd_en   = 1'b1;
               rd_addr = op_addr;
               nb_in   = nb_ff + 2'd1;
            end else begin
               state_in = S_WRITE;
            end
         end
         S_WRITE: begin
            wr_addr = cell_addr;
            wr_data = stencil_ff ? acc_shr[VALUE_W-1:0] : acc_ff[VALUE_W-1:0];
            we_a    = cur_b_ff;
            we_b    = !cur_b_ff;
            state_in = S_CELL;
            if (last_col) begin
               j_in = '0;
               if (last_row) begin
                  // end of sweep: the freshly written store becomes current
                  i_in     = '0;
                  cur_b_in = !cur_b_ff;
                  ticks_in = ticks_ff - TICK_W'(1);
                  state_in = (ticks_ff == TICK_W'(1)) ? S_DONE : S_CELL;
               end else begin
                  i_in = i_ff + IDX_W'(1);
               end
            end else begin
               j_in = j_ff + IDX_W'(1);
            end
         end
         S_DONE: begin
            if (out_free) begin
               rsp_valid_in      = 1'b1;
               rsp_in.reply_kind = REPLY_DONE;
               rsp_in.cell_value = '0;
               state_in          = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cur_b_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cur_b_ff     <= cur_b_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         side_ff       <= SIDE_RESET;
         tick_count_ff <= TICKS_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_SIDE:  side_ff       <= csr_wdata[SIDE_REG_W-1:0];
            CSR_TICKS: tick_count_ff <= csr_wdata[TICK_W-1:0];
            default:   side_ff       <= side_ff;
         endcase
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      ticks_ff   <= ticks_in;
      i_ff       <= i_in;
      j_ff       <= j_in;
      nb_ff      <= nb_in;
      stencil_ff <= stencil_in;
      rd_zero_ff <= rd_zero_in;
      acc_ff     <= acc_in;
      rsp_ff     <= rsp_in;
   end

   // store a
   always_ff @(posedge clock) begin
      if (we_a) begin
         grid_a_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_a_ff <= grid_a_ff[rd_addr];
      end
   end

   // store b
   always_ff @(posedge clock) begin
      if (we_b) begin
         grid_b_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_b_ff <= grid_b_ff[rd_addr];
      end
   end

`ifndef SYNTHESIS
   // a read transaction keeps the block busy in the following cycle
   assert property (@(posedge clock) disable iff (reset)
      (req_fire && (req_data.action == ACT_READ)) |=> !req_ready)
      else $error("block ready right after a read transaction");

   // copied cells take a single operand
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_READ) |-> (stencil_ff || (nb_ff == 2'd0)))
      else $error("copied cell read more than one operand");

   // a reply appears only out of the read-data or done step
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == S_RDATA || $past(state_ff) == S_DONE))
      else $error("reply raised outside the reply steps");

   // the stores are never both written in one cycle
   assert property (@(posedge clock) disable iff (reset)
      !(we_a && we_b))
      else $error("both stores written at once");
`endif

endmodule

### sim/tb_heat_diffusion_stencil.sv
// testbench of the heat diffusion stencil: grid scoreboard, directed cases and random traffic
module tb_heat_diffusion_stencil;
   timeunit 1ns;
   timeprecision 1ps;

   import hds_pkg::*;

   localparam int MAX_SIDE = 64;
   localparam int CELLS = MAX_SIDE * MAX_SIDE;
   // longest quiet stretch: 1023 sweeps of a 2 x 2 grid, taken many times over
   localparam int WATCHDOG_LIMIT = 200000;
   // margin after the last awaited reply; a read reply is registered after the registered store read
   localparam int SETTLE_CYCLES = 8;

   // the one action code the block ignores
   localparam logic [ACTION_W-1:0] ACT_NONE = 2'd3;

   localparam logic signed [VALUE_W-1:0] TEMP_MAX = 24'sh7FFFFF;
   localparam logic signed [VALUE_W-1:0] TEMP_MIN = 24'sh800000;
   localparam logic signed [VALUE_W-1:0] TEMP_ONE = 24'sh000001;

   // grid model of both ping-pong stores plus the replies still to come
   class grid_scoreboard;
      logic signed [VALUE_W-1:0] cells [2][CELLS];
      bit                        written [2][CELLS];
      bit                        current;
      int unsigned               side;
      int unsigned               ticks;
      rsp_type                   awaited_replies [$];
      int                        errors;

      function new();
         current = 1'b0;
         side = SIDE_RESET;
         ticks = TICKS_RESET;
         errors = 0;
      endfunction

      function void write_register(logic [CSR_INDEX_W-1:0] index,
                                   logic [CSR_DATA_W-1:0] data);
         if (index == CSR_SIDE) begin
            side = data[SIDE_REG_W-1:0];
         end else if (index == CSR_TICKS) begin
            ticks = data[TICK_W-1:0];
         end
      endfunction

      function int unsigned side_in_use();
         return (side > MAX_SIDE) ? MAX_SIDE : side;
      endfunction

      function bit is_written(int unsigned row, int unsigned col);
         return written[current][row * MAX_SIDE + col];
      endfunction

      // next written cell of the current store, searching on from the given one
      function bit find_written(inout int unsigned row, inout int unsigned col);
         int unsigned start, n, k;
         start = row * MAX_SIDE + col;
         for (n = 0; n < CELLS; n++) begin
            k = (start + n) % CELLS;
            if (written[current][k]) begin
               row = k / MAX_SIDE;
               col = k % MAX_SIDE;
               return 1'b1;
            end
         end
         return 1'b0;
      endfunction

      // one jacobi sweep from store src into the other one
      function void sweep(bit src, int unsigned s);
         int unsigned i, j, k, mid;
         bit dst, pinned, interior;
         logic signed [SUM_W-1:0] total;
         dst = !src;
         mid = s / 2;
         for (i = 0; i < s; i++) begin
            for (j = 0; j < s; j++) begin
               k = i * MAX_SIDE + j;
               pinned = (i == mid && j == mid) || (i == 1 && j == 1);
               interior = i > 0 && i + 1 < s && j > 0 && j + 1 < s;
               if (interior && !pinned) begin
                  total = cells[src][k - MAX_SIDE] + cells[src][k + MAX_SIDE]
                        + cells[src][k - 1] + cells[src][k + 1];
                  // dropping two bits of the signed sum floors the quarter
                  cells[dst][k] = total[SUM_W-1:2];
               end else begin
                  cells[dst][k] = cells[src][k];
               end
               written[dst][k] = 1'b1;
            end
         end
      endfunction

      function void take_request(req_type r);
         int unsigned k, t, s;
         bit in_store;
         rsp_type reply;
         in_store = r.row < MAX_SIDE && r.col < MAX_SIDE;
         k = in_store ? r.row * MAX_SIDE + r.col : 0;
         case (r.action)
            ACT_WRITE: begin
               if (in_store) begin
                  cells[current][k] = r.value;
                  written[current][k] = 1'b1;
               end
            end
            ACT_RUN: begin
               s = side_in_use();
               for (t = 0; t < ticks; t++) begin
                  sweep(current, s);
                  current = !current;
               end
               reply.reply_kind = REPLY_DONE;
               reply.cell_value = '0;
               awaited_replies.push_back(reply);
            end
            ACT_READ: begin
               reply.reply_kind = REPLY_READ;
               reply.cell_value = in_store ? cells[current][k] : '0;
               awaited_replies.push_back(reply);
            end
            default: begin
            end
         endcase
      endfunction

      function void check_reply(rsp_type got);
         rsp_type want;
         if (awaited_replies.size() == 0) begin
            $error("reply with nothing awaited: reply_kind %0d cell_value %0d",
                   got.reply_kind, got.cell_value);
            errors++;
         end else begin
            want = awaited_replies.pop_front();
            if (got.reply_kind !== want.reply_kind) begin
               $error("reply_kind: expected %0d, actual %0d", want.reply_kind, got.reply_kind);
               errors++;
            end
            if (got.cell_value !== want.cell_value) begin
               $error("cell_value: expected %0d, actual %0d", want.cell_value, got.cell_value);
               errors++;
            end
         end
      endfunction

      function int pending_count();
         return awaited_replies.size();
      endfunction
   endclass

   // clock, reset and block inputs, all known from time zero
   logic clock = 1'b0;
   logic reset = 1'b1;

   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;

   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   // idle percentages of the sender and the receiver, changed between phases
   int send_idle_pct = 38;
   int recv_idle_pct = 82;

   int stall_cycles = 0;

   grid_scoreboard ledger;

   heat_diffusion_stencil #(
      .MAX_SIDE(MAX_SIDE)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data (rsp_data),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always #4 clock = ~clock;

   // receiver back-pressure, redrawn every cycle on the falling edge
   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // every accepted reply transaction is checked against the oldest awaited one
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         ledger.check_reply(rsp_data);
      end
   end

   // watchdog: too long without any transaction on any channel ends the run
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)
          || (csr_valid && csr_ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= WATCHDOG_LIMIT) begin
         $display("FAIL heat_diffusion_stencil");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   function automatic req_type make_req(input logic [ACTION_W-1:0] action,
                                        input int unsigned row, input int unsigned col,
                                        input logic signed [VALUE_W-1:0] value);
      req_type r;
      r.action = action;
      r.row = ROW_W'(row);
      r.col = COL_W'(col);
      r.value = value;
      return r;
   endfunction

   // temperatures lean on the extremes and on values around zero
   function automatic logic signed [VALUE_W-1:0] random_temp();
      case ($urandom_range(7))
         0: return TEMP_MAX;
         1: return TEMP_MIN;
         2: return '0;
         3: return -24'sd1;
         default: return VALUE_W'($urandom);
      endcase
   endfunction

   // cell mostly inside the grid in use, sometimes anywhere in the store
   function automatic void pick_cell(output int unsigned row, output int unsigned col);
      int unsigned s;
      s = ledger.side_in_use();
      if (s > 0 && $urandom_range(3) != 0) begin
         row = $urandom_range(s - 1);
         col = $urandom_range(s - 1);
      end else begin
         row = $urandom_range(MAX_SIDE - 1);
         col = $urandom_range(MAX_SIDE - 1);
      end
   endfunction

   // one request transaction; valid is lowered only for a random gap and
   // raised again on a later falling edge, never twice in one step
   task automatic issue(input req_type r);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data <= r;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      ledger.take_request(r);
   endtask

   task automatic write_cell(input int unsigned row, input int unsigned col,
                             input logic signed [VALUE_W-1:0] value);
      issue(make_req(ACT_WRITE, row, col, value));
   endtask

   // reads of cells never written are outside the contract and are skipped
   task automatic read_cell(input int unsigned row, input int unsigned col);
      if (ledger.is_written(row, col)) begin
         issue(make_req(ACT_READ, row, col, random_temp()));
      end
   endtask

   // load every cell of the grid in use that the current store lacks
   task automatic fill_region();
      int unsigned s, i, j;
      s = ledger.side_in_use();
      for (i = 0; i < s; i++) begin
         for (j = 0; j < s; j++) begin
            if (!ledger.is_written(i, j)) begin
               write_cell(i, j, random_temp());
            end
         end
      end
   endtask

   // a run needs the whole grid in use loaded first
   task automatic run_sweeps();
      fill_region();
      issue(make_req(ACT_RUN, $urandom_range(MAX_SIDE - 1), $urandom_range(MAX_SIDE - 1),
                     random_temp()));
   endtask

   // sender holds off until every awaited reply is in, then the block settles
   task automatic wait_for_replies();
      @(negedge clock);
      req_valid <= 1'b0;
      while (ledger.pending_count() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(input logic [CSR_INDEX_W-1:0] index,
                                 input logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      ledger.write_register(index, data);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // registers change only with the block idle; spare upper bits of the side
   // write are random, so the masking is exercised too
   task automatic configure(input int unsigned side, input int unsigned ticks);
      logic [CSR_DATA_W-1:0] data;
      wait_for_replies();
      data = CSR_DATA_W'($urandom);
      data[SIDE_REG_W-1:0] = SIDE_REG_W'(side);
      write_register(CSR_SIDE, data);
      write_register(CSR_TICKS, CSR_DATA_W'(ticks));
   endtask

   // mostly well-formed traffic: loaded grid, writes, reads of written cells,
   // runs, with some ignored transactions and full drains mixed in
   task automatic random_phase(input int count);
      int done, pick;
      int unsigned row, col;
      done = 0;
      fill_region();
      while (done < count) begin
         pick = $urandom_range(99);
         if (pick < 8) begin
            run_sweeps();
            done++;
         end else if (pick < 12) begin
            issue(make_req(ACT_NONE, $urandom_range(MAX_SIDE - 1),
                           $urandom_range(MAX_SIDE - 1), random_temp()));
         end else if (pick < 15) begin
            wait_for_replies();
         end else if (pick < 55) begin
            pick_cell(row, col);
            write_cell(row, col, random_temp());
            done++;
         end else begin
            pick_cell(row, col);
            if (ledger.find_written(row, col)) begin
               read_cell(row, col);
            end else begin
               write_cell(row, col, random_temp());
            end
            done++;
         end
      end
   endtask

   task automatic phase(input int unsigned side, input int unsigned ticks, input int count,
                        input int send_pct, input int recv_pct);
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      configure(side, ticks);
      random_phase(count);
   endtask

   initial begin
      ledger = new();
      repeat (11) @(negedge clock);
      reset <= 1'b0;

      // directed part at the reset configuration: side 10, ten sweeps
      write_cell(0, 0, TEMP_MAX);
      write_cell(0, MAX_SIDE - 1, TEMP_MIN);
      write_cell(MAX_SIDE - 1, 0, -24'sd1);
      write_cell(MAX_SIDE - 1, MAX_SIDE - 1, TEMP_ONE);
      read_cell(0, 0);
      read_cell(0, MAX_SIDE - 1);
      read_cell(MAX_SIDE - 1, 0);
      read_cell(MAX_SIDE - 1, MAX_SIDE - 1);
      // unknown action with every field bit set must leave the corner alone
      issue(make_req(ACT_NONE, MAX_SIDE - 1, MAX_SIDE - 1, -24'sd1));
      read_cell(MAX_SIDE - 1, MAX_SIDE - 1);
      fill_region();
      // four hottest neighbours round (3,3), four coldest round (7,7): widest sums
      write_cell(2, 3, TEMP_MAX);
      write_cell(4, 3, TEMP_MAX);
      write_cell(3, 2, TEMP_MAX);
      write_cell(3, 4, TEMP_MAX);
      write_cell(6, 7, TEMP_MIN);
      write_cell(8, 7, TEMP_MIN);
      write_cell(7, 6, TEMP_MIN);
      write_cell(7, 8, TEMP_MIN);
      // pinned centre and pinned (1,1) with opposite extremes
      write_cell(5, 5, TEMP_MAX);
      write_cell(1, 1, TEMP_MIN);
      run_sweeps();
      read_cell(5, 5);
      read_cell(1, 1);
      read_cell(3, 3);
      read_cell(7, 7);
      read_cell(0, 9);
      read_cell(MAX_SIDE - 1, MAX_SIDE - 1);
      // zero ticks: nothing swept, still a done reply
      configure(SIDE_RESET, 0);
      run_sweeps();
      read_cell(3, 3);

      // sender idles less than it sends, receiver mostly stalls
      phase(5, 4, 110, 38, 82);
      phase(2, 1023, 30, 38, 82);
      phase(1, 7, 40, 38, 82);
      // side zero sweeps nothing yet still swaps the stores
      phase(0, 5, 40, 38, 82);

      // the other way round
      phase(8, 2, 110, 82, 38);
      phase(6, 0, 60, 82, 38);
      phase(3, 9, 80, 82, 38);

      // no idling on either side
      phase(7, 5, 100, 0, 0);
      phase(4, 1, 80, 0, 0);

      wait_for_replies();
      if (ledger.errors == 0 && ledger.pending_count() == 0) begin
         $display("PASS heat_diffusion_stencil");
      end else begin
         $display("FAIL heat_diffusion_stencil");
      end
      $finish;
   end

endmodule
